[rtl/dsse_pkg.sv]
// Shared widths, register codes and status types for the DoG extremum detector.
`timescale 1ns / 1ps

package dsse_pkg;

  // result position fields
  localparam int ROW_W     = 12;
  localparam int COL_OUT_W = 10;
  // width of the signed-free scratch space used for position arithmetic
  localparam int POS_W     = 13;

  // configuration register widths
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int RADIUS_REG_W = 2;
  localparam int OCTAVE_W     = 3;
  localparam int SCALE_W      = 4;

  localparam int MAX_HEIGHT = 4096;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_TAG    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_TAG     = 3'd4;

  localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH   = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT  = 13'd768;
  localparam logic [RADIUS_REG_W-1:0] RST_WINDOW_RADIUS = 2'd1;
  localparam logic [OCTAVE_W-1:0]     RST_OCTAVE_TAG    = 3'd0;
  localparam logic [SCALE_W-1:0]      RST_SCALE_TAG     = 4'd1;

  // layer slices inside one packed column element
  localparam int NUM_LAYERS = 3;
  localparam int LYR_BELOW  = 0;
  localparam int LYR_MIDDLE = 1;
  localparam int LYR_ABOVE  = 2;

  // position of a beat: test flag plus window center
  typedef struct packed {
    logic                 test;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
  } pos_t;

  typedef struct packed {
    logic found;
    logic is_max;
  } det_t;

endpackage

[rtl/dog_scale_space_extremum_detect.sv]
// Top level of the streaming 3-layer DoG scale-space extremum detector.
//
//  channel | ports                                         | transfer
//  --------+-----------------------------------------------+---------------------------
//  in      | in_valid, in_stall, in_start_of_frame, samples | beat when valid & !stall
//  out     | out_valid, out_stall, row/col/response/tags    | beat when valid & !stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | write when valid & ready
//
// One input beat per cycle sustained while in_stall is low. A detection raises out_valid once
// its beat has passed the input register, the row bank read and the window register, and the
// compare result is caught by the output register.
// Reset clears position counters and stage valids and loads the register defaults; row
// banks are not cleared and hold nothing until written. out_stall holds the output register;
// upstream stages keep moving into empty slots, so in_stall rises only when all are full.
`timescale 1ns / 1ps

module dog_scale_space_extremum_detect #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_RADIUS  = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,

  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_start_of_frame,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_below,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_middle,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_above,

  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [dsse_pkg::ROW_W-1:0]             out_row,
  output logic [dsse_pkg::COL_OUT_W-1:0]         out_col,
  output logic signed [SAMPLE_BITS-1:0]          out_response,
  output logic                                   out_is_maximum,
  output logic [dsse_pkg::OCTAVE_W-1:0]          out_octave,
  output logic [dsse_pkg::SCALE_W-1:0]           out_scale,

  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dsse_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dsse_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int NROWS = 2 * MAX_RADIUS + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int SW    = $clog2(NROWS);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int CB    = dsse_pkg::NUM_LAYERS * SAMPLE_BITS;
  localparam int PW    = dsse_pkg::POS_W;

  // configuration registers
  logic [dsse_pkg::WIDTH_REG_W-1:0]  width_r;
  logic [dsse_pkg::HEIGHT_REG_W-1:0] height_r;
  logic [dsse_pkg::RADIUS_REG_W-1:0] radius_r;
  logic [dsse_pkg::OCTAVE_W-1:0]     octave_r;
  logic [dsse_pkg::SCALE_W-1:0]      scale_r;

  logic [WW-1:0]                     w_eff;
  logic [dsse_pkg::HEIGHT_REG_W-1:0] h_eff;
  logic [RW-1:0]                     r_eff;

  // pipeline
  logic                  adv1, adv2, adv3, out_free, in_fire, hit3;
  dsse_pkg::pos_t        cur_pos;
  logic [CW-1:0]         cur_col;
  logic [SW-1:0]         cur_slot;

  logic                  s1_v_r, s2_v_r, s3_v_r;
  dsse_pkg::pos_t        s1_pos_r, s2_pos_r, s3_pos_r;
  logic [CW-1:0]         s1_col_r;
  logic [SW-1:0]         s1_slot_r;
  logic [CB-1:0]         s1_smp_r;

  logic [CB-1:0]         age_col [NROWS];
  dsse_pkg::det_t        det;
  logic signed [SAMPLE_BITS-1:0] center;

  logic                  out_v_r;
  logic [dsse_pkg::ROW_W-1:0]     out_row_r;
  logic [dsse_pkg::COL_OUT_W-1:0] out_col_r;
  logic signed [SAMPLE_BITS-1:0]  out_resp_r;
  logic                           out_max_r;
  logic [dsse_pkg::OCTAVE_W-1:0]  out_oct_r;
  logic [dsse_pkg::SCALE_W-1:0]   out_scl_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dsse_pkg::RST_IMAGE_WIDTH;
      height_r <= dsse_pkg::RST_IMAGE_HEIGHT;
      radius_r <= dsse_pkg::RST_WINDOW_RADIUS;
      octave_r <= dsse_pkg::RST_OCTAVE_TAG;
      scale_r  <= dsse_pkg::RST_SCALE_TAG;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dsse_pkg::CFG_IMAGE_WIDTH:   width_r  <= cfg_data[dsse_pkg::WIDTH_REG_W-1:0];
        dsse_pkg::CFG_IMAGE_HEIGHT:  height_r <= cfg_data[dsse_pkg::HEIGHT_REG_W-1:0];
        dsse_pkg::CFG_WINDOW_RADIUS: radius_r <= cfg_data[dsse_pkg::RADIUS_REG_W-1:0];
        dsse_pkg::CFG_OCTAVE_TAG:    octave_r <= cfg_data[dsse_pkg::OCTAVE_W-1:0];
        dsse_pkg::CFG_SCALE_TAG:     scale_r  <= cfg_data[dsse_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp register values into the supported range
  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (PW'(width_r) > PW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end

    if (height_r == '0) begin
      h_eff = dsse_pkg::HEIGHT_REG_W'(1);
    end else if (PW'(height_r) > PW'(dsse_pkg::MAX_HEIGHT)) begin
      h_eff = dsse_pkg::HEIGHT_REG_W'(dsse_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end

    if (PW'(radius_r) > PW'(MAX_RADIUS)) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(radius_r);
    end
  end

  // stage handshake: each stage moves when the one ahead is empty or moving
  assign out_free = !out_v_r || !out_stall;
  assign hit3     = s3_v_r && s3_pos_r.test && det.found;
  assign adv3     = !hit3 || out_free;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_stall = !adv1;
  assign in_fire  = in_valid && adv1;

  dsse_pos_ctr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .sof      (in_start_of_frame),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .r_eff    (r_eff),
    .cur_pos  (cur_pos),
    .cur_col  (cur_col),
    .cur_slot (cur_slot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_valid;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_pos_r  <= cur_pos;
      s1_col_r  <= cur_col;
      s1_slot_r <= cur_slot;
      s1_smp_r  <= {in_sample_above, in_sample_middle, in_sample_below};
    end
    if (adv2) s2_pos_r <= s1_pos_r;
    if (adv3) s3_pos_r <= s2_pos_r;
  end

  dsse_line_store #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lines (
    .clk     (clk),
    .en      (adv2),
    .wr_en   (s1_v_r),
    .addr    (s1_col_r),
    .slot    (s1_slot_r),
    .wr_data (s1_smp_r),
    .age_col (age_col)
  );

  dsse_window #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_win (
    .clk      (clk),
    .shift_en (adv3 && s2_v_r),
    .col_in   (age_col),
    .r_eff    (r_eff),
    .det      (det),
    .center   (center)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= hit3;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && hit3) begin
      out_row_r  <= s3_pos_r.row;
      out_col_r  <= s3_pos_r.col;
      out_resp_r <= center;
      out_max_r  <= det.is_max;
      out_oct_r  <= octave_r;
      out_scl_r  <= scale_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_response   = out_resp_r;
  assign out_is_maximum = out_max_r;
  assign out_octave     = out_oct_r;
  assign out_scale      = out_scl_r;

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && s1_v_r && s2_v_r && s3_v_r))
    else $error("input stalled with room in the pipeline");

  a_blocked_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (hit3 && !out_free) |=> (s3_v_r && $stable(s3_pos_r)))
    else $error("blocked detection left the compare stage");
`endif

endmodule

[rtl/dsse_pos_ctr.sv]
// Raster position counters, row bank pointer and test decision for each input beat.
`timescale 1ns / 1ps

module dsse_pos_ctr #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  logic                                sof,
  input  logic [$clog2(MAX_WIDTH):0]          w_eff,
  input  logic [dsse_pkg::HEIGHT_REG_W-1:0]   h_eff,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]     r_eff,
  output dsse_pkg::pos_t                      cur_pos,
  output logic [$clog2(MAX_WIDTH)-1:0]        cur_col,
  output logic [$clog2(2*MAX_RADIUS+1)-1:0]   cur_slot
);

  localparam int NROWS = 2 * MAX_RADIUS + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(NROWS);
  localparam int PW    = dsse_pkg::POS_W;
  localparam int RWD   = dsse_pkg::ROW_W;

  logic [RWD-1:0] row_r, row_nxt, row_cur;
  logic [CW-1:0]  col_r, col_nxt, col_cur;
  logic [SW-1:0]  slot_r, slot_nxt, slot_cur;
  logic [PW-1:0]  row_w, col_w, rad_w, span_w, ctr_row_w, ctr_col_w;

  always_comb begin
    row_cur  = sof ? '0 : row_r;
    col_cur  = sof ? '0 : col_r;
    slot_cur = sof ? '0 : slot_r;

    row_w  = PW'(row_cur);
    col_w  = PW'(col_cur);
    rad_w  = PW'(r_eff);
    span_w = rad_w << 1;

    cur_pos.test = (row_w >= span_w) && (col_w >= span_w) &&
                   (row_w < PW'(h_eff)) && (col_w < PW'(w_eff));
    ctr_row_w   = row_w - rad_w;
    ctr_col_w   = col_w - rad_w;
    cur_pos.row = ctr_row_w[dsse_pkg::ROW_W-1:0];
    cur_pos.col = ctr_col_w[dsse_pkg::COL_OUT_W-1:0];
    cur_col     = col_cur;
    cur_slot    = slot_cur;

    // a counter left beyond a shrunk size wraps on its next advance
    if (col_w + PW'(1) >= PW'(w_eff)) begin
      col_nxt = '0;
      if (row_w + PW'(1) >= PW'(h_eff)) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = row_cur + RWD'(1);
        slot_nxt = (slot_cur == SW'(NROWS - 1)) ? '0 : slot_cur + SW'(1);
      end
    end else begin
      col_nxt  = col_cur + CW'(1);
      row_nxt  = row_cur;
      slot_nxt = slot_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (fire) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < SW'(NROWS))
    else $error("row bank pointer out of range");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(row_r) && $stable(col_r) && $stable(slot_r)))
    else $error("position moved without an input beat");

  a_origin_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r == '0 && col_r == '0) |-> (slot_r == '0))
    else $error("row bank pointer out of step with row counter");
`endif

endmodule

[rtl/dsse_line_store.sv]
// Row banks for the three layers, one bank per stored row, and column assembly by row age.
`timescale 1ns / 1ps

module dsse_line_store #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_RADIUS  = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                             clk,
  input  logic                                             en,
  input  logic                                             wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]                     addr,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0]                slot,
  input  logic [dsse_pkg::NUM_LAYERS*SAMPLE_BITS-1:0]      wr_data,
  output logic [dsse_pkg::NUM_LAYERS*SAMPLE_BITS-1:0]      age_col [2*MAX_RADIUS+1]
);

  localparam int NROWS = 2 * MAX_RADIUS + 1;
  localparam int SW    = $clog2(NROWS);
  localparam int CB    = dsse_pkg::NUM_LAYERS * SAMPLE_BITS;

  logic [CB-1:0] rd_data [NROWS];
  logic [CB-1:0] data2_r;
  logic [SW-1:0] slot2_r;
  logic [SW-1:0] age_idx [NROWS];

  for (genvar k = 0; k < NROWS; k++) begin : g_bank
    logic [CB-1:0] mem [MAX_WIDTH];
    logic [CB-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (en) begin
        if (wr_en && slot == SW'(k)) begin
          mem[addr] <= wr_data;
        end
        rd_r <= mem[addr];
      end
    end

    assign rd_data[k] = rd_r;
  end

  // the beat's own bank is read back from the bypass, not the RAM
  always_ff @(posedge clk) begin
    if (en) begin
      slot2_r <= slot;
      data2_r <= wr_data;
    end
  end

  always_comb begin
    for (int d = 0; d < NROWS; d++) begin
      age_idx[d] = (slot2_r >= SW'(d)) ? slot2_r - SW'(d)
                                       : SW'(int'(slot2_r) + NROWS - d);
      age_col[d] = (d == 0) ? data2_r : rd_data[age_idx[d]];
    end
  end

endmodule

[rtl/dsse_window.sv]
// Window column shift registers and parallel strict-extremum compare.
`timescale 1ns / 1ps

module dsse_window #(
  parameter int MAX_RADIUS  = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          shift_en,
  input  logic [dsse_pkg::NUM_LAYERS*SAMPLE_BITS-1:0]   col_in [2*MAX_RADIUS+1],
  input  logic [$clog2(MAX_RADIUS+1)-1:0]               r_eff,
  output dsse_pkg::det_t                                det,
  output logic signed [SAMPLE_BITS-1:0]                 center
);

  localparam int NROWS = 2 * MAX_RADIUS + 1;
  localparam int CB    = dsse_pkg::NUM_LAYERS * SAMPLE_BITS;
  localparam int IW    = $clog2(NROWS);
  localparam int SB    = SAMPLE_BITS;

  // win_r[c][d]: c columns back from the newest, d rows back from the newest
  logic [CB-1:0] win_r [NROWS][NROWS];

  logic [IW-1:0]              ctr_idx;
  logic signed [SB-1:0]       ctr_v, q_b, q_m, q_a;
  logic                       in_win, is_ctr;
  logic [NROWS*NROWS-1:0]     min_ok, max_ok;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r[0] <= col_in;
      for (int c = 1; c < NROWS; c++) begin
        win_r[c] <= win_r[c-1];
      end
    end
  end

  always_comb begin
    ctr_idx = IW'(r_eff);
    ctr_v   = win_r[ctr_idx][ctr_idx][dsse_pkg::LYR_MIDDLE*SB +: SB];
    for (int c = 0; c < NROWS; c++) begin
      for (int d = 0; d < NROWS; d++) begin
        q_b    = win_r[c][d][dsse_pkg::LYR_BELOW*SB +: SB];
        q_m    = win_r[c][d][dsse_pkg::LYR_MIDDLE*SB +: SB];
        q_a    = win_r[c][d][dsse_pkg::LYR_ABOVE*SB +: SB];
        in_win = (c <= 2 * int'(r_eff)) && (d <= 2 * int'(r_eff));
        is_ctr = (c == int'(r_eff)) && (d == int'(r_eff));
        // the center is compared against its own below/above samples too
        min_ok[c*NROWS+d] = !in_win ||
                            ((is_ctr || ctr_v < q_m) && ctr_v < q_b && ctr_v < q_a);
        max_ok[c*NROWS+d] = !in_win ||
                            ((is_ctr || ctr_v > q_m) && ctr_v > q_b && ctr_v > q_a);
      end
    end
    det.found  = (&min_ok) || (&max_ok);
    det.is_max = &max_ok;
    center     = ctr_v;
  end

endmodule
